FILE: design/obls_pkg.sv
// obls_pkg: types, sizes and codes for the order book level synchronizer
// no dependencies; used by obls_level_engine and order_book_level_sync
package obls_pkg;

  localparam int LEVELS_PER_SIDE = 1024;
  localparam int IDX_W   = $clog2(LEVELS_PER_SIDE);
  localparam int CNT_W   = IDX_W + 1;
  localparam int PRICE_W = 32;
  localparam int QTY_W   = 32;
  localparam int ID_W    = 63;

  localparam logic [1:0] REQ_BEGIN      = 2'd0;
  localparam logic [1:0] REQ_SNAP_LEVEL = 2'd1;
  localparam logic [1:0] REQ_COMMIT     = 2'd2;
  localparam logic [1:0] REQ_DIFF       = 2'd3;

  localparam logic [2:0] ST_APPLIED  = 3'd0;
  localparam logic [2:0] ST_STALE    = 3'd1;
  localparam logic [2:0] ST_GAP      = 3'd2;
  localparam logic [2:0] ST_IGNORED  = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;
  localparam logic [2:0] ST_BRACKET  = 3'd5;
  localparam logic [2:0] NO_EVENT    = 3'd7;

  typedef enum logic [1:0] {
    PH_UNSYNCED, PH_LOADING, PH_AWAIT, PH_SYNCED
  } phase_t;

  typedef enum logic {T_IDLE, T_RUN} top_state_t;

  typedef enum logic [2:0] {
    P_IDLE, P_SRD, P_SCHK, P_DEC, P_IRD, P_IWR, P_IPUT, P_ERD
  } put_state_t;

  typedef struct packed {
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   qty;
  } level_t;

  typedef struct packed {
    logic [1:0]         req_type;
    logic               book_side;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   quantity;
    logic [ID_W-1:0]    first_id;
    logic [ID_W-1:0]    final_id;
    logic [ID_W-1:0]    prev_id;
    logic               last_of_event;
  } req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [PRICE_W-1:0] best_bid_price;
    logic [PRICE_W-1:0] best_ask_price;
    logic [CNT_W-1:0]   bid_level_count;
    logic [CNT_W-1:0]   ask_level_count;
    logic [ID_W-1:0]    book_update_id;
    logic               in_sync;
  } rsp_t;

  typedef struct packed {
    logic               go;
    logic               clear;
    logic               side;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   qty;
  } put_cmd_t;

endpackage

FILE: design/obls_level_engine.sv
// obls_level_engine: sorted level memory for both sides with linear search
// and shift-based insert / erase; depends on obls_pkg
module obls_level_engine (
  input  logic                        clk,
  input  logic                        rst,
  input  obls_pkg::put_cmd_t          cmd,
  output logic                        done,
  output logic                        full,
  output logic [obls_pkg::CNT_W-1:0]  bid_cnt,
  output logic [obls_pkg::CNT_W-1:0]  ask_cnt,
  output logic [obls_pkg::PRICE_W-1:0] best_bid,
  output logic [obls_pkg::PRICE_W-1:0] best_ask
);

  localparam int AW = obls_pkg::IDX_W + 1;
  localparam logic [obls_pkg::CNT_W-1:0] ONE = obls_pkg::CNT_W'(1);
  localparam logic [obls_pkg::CNT_W-1:0] LEV = obls_pkg::CNT_W'(obls_pkg::LEVELS_PER_SIDE);

  obls_pkg::level_t mem [2*obls_pkg::LEVELS_PER_SIDE];
  obls_pkg::level_t rdata, wdata;
  logic             rd_en, we;
  logic [AW-1:0]    raddr, waddr;

  obls_pkg::put_state_t state, state_next;
  logic                       side, found;
  logic [obls_pkg::PRICE_W-1:0] price;
  logic [obls_pkg::QTY_W-1:0]   qty;
  logic [obls_pkg::CNT_W-1:0]   n, i, j;
  logic                       ordered;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (rd_en) rdata <= mem[raddr];
  end

  // continue search while the stored price ranks ahead of the new one
  assign ordered = side ? (rdata.price < price) : (rdata.price > price);

  always_comb begin
    state_next = state;
    unique case (state)
      obls_pkg::P_IDLE: if (cmd.go) state_next = obls_pkg::P_SRD;
      obls_pkg::P_SRD:  state_next = obls_pkg::P_SCHK;
      obls_pkg::P_SCHK:
        state_next = (ordered && (i + ONE != n)) ? obls_pkg::P_SRD : obls_pkg::P_DEC;
      obls_pkg::P_DEC: begin
        if (qty == '0) begin
          state_next = (found && (i + ONE != n)) ? obls_pkg::P_ERD : obls_pkg::P_IDLE;
        end else if (found || n >= LEV) begin
          state_next = obls_pkg::P_IDLE;
        end else begin
          state_next = (i == n) ? obls_pkg::P_IPUT : obls_pkg::P_IRD;
        end
      end
      obls_pkg::P_IRD:  state_next = obls_pkg::P_IWR;
      obls_pkg::P_IWR:  state_next = (j - ONE == i) ? obls_pkg::P_IPUT : obls_pkg::P_IRD;
      obls_pkg::P_IPUT: state_next = obls_pkg::P_IDLE;
      obls_pkg::P_ERD:  state_next = obls_pkg::P_IWR;
      default: state_next = obls_pkg::P_IDLE;
    endcase
    // empty side: nothing to search
    if (state == obls_pkg::P_IDLE && cmd.go && (cmd.side ? ask_cnt : bid_cnt) == '0)
      state_next = obls_pkg::P_DEC;
    if (state == obls_pkg::P_IWR && qty == '0) begin
      state_next = (j + ONE + ONE == n) ? obls_pkg::P_IDLE : obls_pkg::P_ERD;
    end
  end

  always_comb begin
    rd_en = 1'b0;
    raddr = {side, i[obls_pkg::IDX_W-1:0]};
    we    = 1'b0;
    waddr = {side, i[obls_pkg::IDX_W-1:0]};
    wdata = '{price: price, qty: qty};
    unique case (state)
      obls_pkg::P_SRD: rd_en = 1'b1;
      obls_pkg::P_IRD: begin
        rd_en = 1'b1;
        raddr = {side, j[obls_pkg::IDX_W-1:0] - obls_pkg::IDX_W'(1)};
      end
      obls_pkg::P_ERD: begin
        rd_en = 1'b1;
        raddr = {side, j[obls_pkg::IDX_W-1:0] + obls_pkg::IDX_W'(1)};
      end
      obls_pkg::P_IWR: begin
        we    = 1'b1;
        waddr = {side, j[obls_pkg::IDX_W-1:0]};
        wdata = rdata;
      end
      obls_pkg::P_DEC:  we = (qty != '0) && found;
      obls_pkg::P_IPUT: we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= obls_pkg::P_IDLE;
      done    <= 1'b0;
      full    <= 1'b0;
      bid_cnt <= '0;
      ask_cnt <= '0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      full  <= 1'b0;
      if (cmd.clear) begin
        bid_cnt <= '0;
        ask_cnt <= '0;
      end
      unique case (state)
        obls_pkg::P_IDLE: if (cmd.go) begin
          side  <= cmd.side;
          price <= cmd.price;
          qty   <= cmd.qty;
          n     <= cmd.side ? ask_cnt : bid_cnt;
          i     <= '0;
          found <= 1'b0;
        end
        obls_pkg::P_SCHK: begin
          if (ordered) i <= i + ONE;
          else found <= (rdata.price == price);
        end
        obls_pkg::P_DEC: begin
          j <= (qty == '0) ? i : n;
          if (qty == '0) begin
            if (found && (i + ONE == n)) begin
              if (side) ask_cnt <= n - ONE;
              else bid_cnt <= n - ONE;
            end
            if (!(found && (i + ONE != n))) done <= 1'b1;
          end else if (found || n >= LEV) begin
            done <= 1'b1;
            full <= !found;
          end
        end
        obls_pkg::P_IWR: begin
          if (qty == '0) begin
            j <= j + ONE;
            if (j + ONE + ONE == n) begin
              done <= 1'b1;
              if (side) ask_cnt <= n - ONE;
              else bid_cnt <= n - ONE;
            end
          end else begin
            j <= j - ONE;
          end
        end
        obls_pkg::P_IPUT: begin
          done <= 1'b1;
          if (side) ask_cnt <= n + ONE;
          else bid_cnt <= n + ONE;
        end
        default: ;
      endcase
    end
  end

  // shadow of entry zero of each side
  always_ff @(posedge clk) begin
    if (we && waddr[obls_pkg::IDX_W-1:0] == '0) begin
      if (waddr[AW-1]) best_ask <= wdata.price;
      else best_bid <= wdata.price;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    bid_cnt <= LEV && ask_cnt <= LEV) else $error("level count past table size");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> state == obls_pkg::P_IDLE) else $error("done while engine busy");
  a_srd_range: assert property (@(posedge clk) disable iff (rst)
    state == obls_pkg::P_SRD |-> i < n) else $error("search read past count");

endmodule

FILE: design/order_book_level_sync.sv
// order_book_level_sync: top level, event sequencing and sync tracking
// depends on obls_pkg and obls_level_engine
// timing: a request that touches no table gives its result in the cycle after it is
//   taken; others run the engine search (read, check per entry), then the shifts and,
//   for an insert, the put, paced by the single read port of the level ram
// throughput: one beat at a time, busy high while the level engine runs
// reset: counts, last id, phase and open event cleared; table contents undefined
// the result beat is shown for one cycle with done, receiver cannot stall
module order_book_level_sync (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  obls_pkg::req_t req,
  output logic           busy,
  output logic           done,
  output obls_pkg::rsp_t rsp
);

  obls_pkg::top_state_t state, state_next;
  obls_pkg::phase_t     phase;
  logic [2:0]           verdict, v_eval, v_use, status;
  logic [obls_pkg::ID_W-1:0] last_id;
  obls_pkg::req_t       req_q;
  obls_pkg::put_cmd_t   cmd;
  logic                 go, accept, needs_put;
  logic                 eng_done, eng_full;
  logic [obls_pkg::CNT_W-1:0]   bid_cnt, ask_cnt;
  logic [obls_pkg::PRICE_W-1:0] best_bid, best_ask;

  assign accept = start && !busy;

  // event verdict, taken on the first level of a diff event
  always_comb begin
    priority if (phase == obls_pkg::PH_UNSYNCED || phase == obls_pkg::PH_LOADING)
      v_eval = obls_pkg::ST_IGNORED;
    else if (req.final_id <= last_id)
      v_eval = obls_pkg::ST_STALE;
    else if (phase == obls_pkg::PH_AWAIT)
      v_eval = (req.first_id > last_id) ? obls_pkg::ST_BRACKET : obls_pkg::ST_APPLIED;
    else
      v_eval = (req.prev_id != last_id) ? obls_pkg::ST_GAP : obls_pkg::ST_APPLIED;
    v_use = (verdict == obls_pkg::NO_EVENT) ? v_eval : verdict;
  end

  always_comb begin
    unique case (req.req_type)
      obls_pkg::REQ_SNAP_LEVEL:
        needs_put = (phase == obls_pkg::PH_LOADING) && (req.quantity != '0);
      obls_pkg::REQ_DIFF: needs_put = (v_use == obls_pkg::ST_APPLIED);
      default: needs_put = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      obls_pkg::T_IDLE: if (accept && needs_put) state_next = obls_pkg::T_RUN;
      obls_pkg::T_RUN:  if (eng_done) state_next = obls_pkg::T_IDLE;
      default: state_next = obls_pkg::T_IDLE;
    endcase
  end

  // outputs and engine command
  always_comb begin
    busy      = (state == obls_pkg::T_RUN);
    cmd.go    = go;
    cmd.clear = accept && (req.req_type == obls_pkg::REQ_BEGIN);
    cmd.side  = req_q.book_side;
    cmd.price = req_q.price;
    cmd.qty   = req_q.quantity;
    rsp.status          = status;
    rsp.best_bid_price  = (bid_cnt != '0) ? best_bid : '0;
    rsp.best_ask_price  = (ask_cnt != '0) ? best_ask : '0;
    rsp.bid_level_count = bid_cnt;
    rsp.ask_level_count = ask_cnt;
    rsp.book_update_id  = last_id;
    rsp.in_sync         = (phase == obls_pkg::PH_SYNCED);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= obls_pkg::T_IDLE;
      phase   <= obls_pkg::PH_UNSYNCED;
      verdict <= obls_pkg::NO_EVENT;
      last_id <= '0;
      go      <= 1'b0;
      done    <= 1'b0;
      status  <= obls_pkg::ST_APPLIED;
    end else begin
      state <= state_next;
      go    <= accept && needs_put;
      done  <= 1'b0;
      if (accept) begin
        req_q  <= req;
        status <= obls_pkg::ST_APPLIED;
        done   <= !needs_put;
        unique case (req.req_type)
          obls_pkg::REQ_BEGIN: begin
            phase   <= obls_pkg::PH_LOADING;
            verdict <= obls_pkg::NO_EVENT;
          end
          obls_pkg::REQ_SNAP_LEVEL:
            if (phase != obls_pkg::PH_LOADING) status <= obls_pkg::ST_IGNORED;
          obls_pkg::REQ_COMMIT: begin
            if (phase != obls_pkg::PH_LOADING) begin
              status <= obls_pkg::ST_IGNORED;
            end else begin
              last_id <= req.final_id;
              phase   <= obls_pkg::PH_AWAIT;
            end
          end
          obls_pkg::REQ_DIFF: begin
            if (verdict == obls_pkg::NO_EVENT) begin
              if (v_eval == obls_pkg::ST_BRACKET || v_eval == obls_pkg::ST_GAP)
                phase <= obls_pkg::PH_UNSYNCED;
              else if (v_eval == obls_pkg::ST_APPLIED)
                phase <= obls_pkg::PH_SYNCED;
            end
            if (v_use != obls_pkg::ST_APPLIED) status <= v_use;
            else if (req.last_of_event) last_id <= req.final_id;
            verdict <= req.last_of_event ? obls_pkg::NO_EVENT : v_use;
          end
          default: ;
        endcase
      end
      if (state == obls_pkg::T_RUN && eng_done) begin
        done   <= 1'b1;
        status <= eng_full ? obls_pkg::ST_FULL : obls_pkg::ST_APPLIED;
      end
    end
  end

  obls_level_engine u_engine (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .done     (eng_done),
    .full     (eng_full),
    .bid_cnt  (bid_cnt),
    .ask_cnt  (ask_cnt),
    .best_bid (best_bid),
    .best_ask (best_ask)
  );

  a_go_run: assert property (@(posedge clk) disable iff (rst)
    go |-> state == obls_pkg::T_RUN) else $error("engine started outside run");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> state == obls_pkg::T_IDLE) else $error("result beat while busy");
  a_eng_done: assert property (@(posedge clk) disable iff (rst)
    eng_done |-> $past(state) == obls_pkg::T_RUN) else $error("stray engine done");

endmodule

FILE: sim/order_book_level_sync_tb.sv
// order_book_level_sync_tb: self-checking bench for the order book level synchronizer
// depends on obls_pkg and order_book_level_sync; holds its own book model in queues
`timescale 1ns / 100ps

module order_book_level_sync_tb;
  import obls_pkg::*;

  localparam int RANDOM_ITEMS = 600;
  localparam int STALL_LIMIT  = 20000;  // limit set well above the worst search plus shift of a full side

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  req_t req = '0;
  logic busy;
  logic done;
  rsp_t rsp;

  order_book_level_sync u_dut (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .req  (req),
    .busy (busy),
    .done (done),
    .rsp  (rsp)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // book model: sorted price/qty queues per side, phase, last id, open event
  // ---------------------------------------------------------------------------
  logic [PRICE_W-1:0] bid_px[$];
  logic [QTY_W-1:0]   bid_qt[$];
  logic [PRICE_W-1:0] ask_px[$];
  logic [QTY_W-1:0]   ask_qt[$];
  logic [ID_W-1:0]    book_last_id = '0;
  phase_t             book_phase = PH_UNSYNCED;
  logic [2:0]         open_verdict = NO_EVENT;

  // set, insert or erase one level; full only when a new price meets a full side
  function automatic logic [2:0] book_put(logic side, logic [PRICE_W-1:0] px,
                                          logic [QTY_W-1:0] q);
    int n;
    int i;
    bit found;
    n = side ? ask_px.size() : bid_px.size();
    i = 0;
    while (i < n && (side ? ask_px[i] < px : bid_px[i] > px)) i++;
    found = (i < n) && ((side ? ask_px[i] : bid_px[i]) == px);
    if (q == '0) begin
      if (found) begin
        if (side) begin
          ask_px.delete(i);
          ask_qt.delete(i);
        end else begin
          bid_px.delete(i);
          bid_qt.delete(i);
        end
      end
      return ST_APPLIED;
    end
    if (found) begin
      if (side) ask_qt[i] = q;
      else bid_qt[i] = q;
      return ST_APPLIED;
    end
    if (n >= LEVELS_PER_SIDE) return ST_FULL;
    if (side) begin
      ask_px.insert(i, px);
      ask_qt.insert(i, q);
    end else begin
      bid_px.insert(i, px);
      bid_qt.insert(i, q);
    end
    return ST_APPLIED;
  endfunction

  // advance the book by one accepted beat and return the result it must give
  function automatic rsp_t book_step(req_t r);
    rsp_t o;
    logic [2:0] st;
    st = ST_APPLIED;
    case (r.req_type)
      REQ_BEGIN: begin
        bid_px.delete();
        bid_qt.delete();
        ask_px.delete();
        ask_qt.delete();
        book_phase = PH_LOADING;
        open_verdict = NO_EVENT;
      end
      REQ_SNAP_LEVEL: begin
        if (book_phase != PH_LOADING) st = ST_IGNORED;
        else if (r.quantity != '0) st = book_put(r.book_side, r.price, r.quantity);
      end
      REQ_COMMIT: begin
        if (book_phase != PH_LOADING) begin
          st = ST_IGNORED;
        end else begin
          book_last_id = r.final_id;
          book_phase = PH_AWAIT;
        end
      end
      default: begin
        // verdict is taken on the first level and held for the whole event
        if (open_verdict == NO_EVENT) begin
          if (book_phase == PH_UNSYNCED || book_phase == PH_LOADING) begin
            open_verdict = ST_IGNORED;
          end else if (r.final_id <= book_last_id) begin
            open_verdict = ST_STALE;
          end else if (book_phase == PH_AWAIT) begin
            if (r.first_id > book_last_id) begin
              open_verdict = ST_BRACKET;
              book_phase = PH_UNSYNCED;
            end else begin
              open_verdict = ST_APPLIED;
              book_phase = PH_SYNCED;
            end
          end else if (r.prev_id != book_last_id) begin
            open_verdict = ST_GAP;
            book_phase = PH_UNSYNCED;
          end else begin
            open_verdict = ST_APPLIED;
          end
        end
        if (open_verdict == ST_APPLIED) begin
          st = book_put(r.book_side, r.price, r.quantity);
          if (r.last_of_event) book_last_id = r.final_id;
        end else begin
          st = open_verdict;
        end
        if (r.last_of_event) open_verdict = NO_EVENT;
      end
    endcase
    o.status          = st;
    o.best_bid_price  = bid_px.size() > 0 ? bid_px[0] : '0;
    o.best_ask_price  = ask_px.size() > 0 ? ask_px[0] : '0;
    o.bid_level_count = CNT_W'(bid_px.size());
    o.ask_level_count = CNT_W'(ask_px.size());
    o.book_update_id  = book_last_id;
    o.in_sync         = (book_phase == PH_SYNCED);
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus generation: well-formed snapshot/event sequences plus noise
  // ---------------------------------------------------------------------------
  req_t       pending_reqs[$];
  rsp_t       expected_rsps[$];
  int         fail_count = 0;
  int         items_made = 0;
  logic [ID_W-1:0] gen_last_id = '0;
  int         gen_mode = 0;   // 0 unsynced, 1 awaiting first event, 2 synced

  task automatic push_req(logic [1:0] kind, logic side, logic [PRICE_W-1:0] px,
                          logic [QTY_W-1:0] q, logic [ID_W-1:0] first,
                          logic [ID_W-1:0] fin, logic [ID_W-1:0] prev, logic last);
    req_t r;
    r.req_type      = kind;
    r.book_side     = side;
    r.price         = px;
    r.quantity      = q;
    r.first_id      = first;
    r.final_id      = fin;
    r.prev_id       = prev;
    r.last_of_event = last;
    pending_reqs.insert(pending_reqs.size(), r);
    items_made++;
  endtask

  function automatic logic [ID_W-1:0] rand_id();
    return ID_W'({$urandom, $urandom});
  endfunction

  // mostly a small pool so that updates and erases hit held levels
  function automatic logic [PRICE_W-1:0] pick_price();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 85) return PRICE_W'(100 + $urandom_range(0, 15));
    if (sel < 95) return $urandom;
    return sel[0] ? '1 : '0;
  endfunction

  function automatic logic [QTY_W-1:0] pick_qty();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 25) return '0;
    if (sel < 32) return '1;
    return $urandom;
  endfunction

  task automatic gen_snapshot(int nlev);
    logic [ID_W-1:0] snap_id;
    push_req(REQ_BEGIN, 1'($urandom), $urandom, $urandom, rand_id(), rand_id(), rand_id(),
             1'($urandom));
    for (int k = 0; k < nlev; k++)
      push_req(REQ_SNAP_LEVEL, 1'($urandom), pick_price(), pick_qty(), rand_id(),
               rand_id(), rand_id(), 1'($urandom));
    snap_id = ID_W'({$urandom_range(0, 32'h3FFF_FFFF), $urandom});
    push_req(REQ_COMMIT, 1'($urandom), $urandom, $urandom, rand_id(), snap_id, rand_id(),
             1'($urandom));
    gen_last_id = snap_id;
    gen_mode = 1;
  endtask

  // levels of one diff event sharing the same ids, last flag on the final level
  task automatic gen_event(int nlev, logic [ID_W-1:0] first, logic [ID_W-1:0] fin,
                           logic [ID_W-1:0] prev);
    for (int k = 0; k < nlev; k++)
      push_req(REQ_DIFF, 1'($urandom), pick_price(), pick_qty(), first, fin, prev,
               k == nlev - 1);
  endtask

  task automatic gen_good_event();
    logic [ID_W-1:0] first;
    logic [ID_W-1:0] fin;
    if (gen_mode == 1) begin
      first = gen_last_id - ID_W'($urandom_range(0, 3));
      fin   = gen_last_id + ID_W'($urandom_range(1, 5));
    end else begin
      first = gen_last_id + 1;
      fin   = first + ID_W'($urandom_range(0, 4));
    end
    gen_event($urandom_range(1, 4), first, fin, gen_last_id);
    gen_last_id = fin;
    gen_mode = 2;
  endtask

  task automatic gen_directed();
    logic [ID_W-1:0] top_id;
    top_id = '1;
    push_req(REQ_DIFF, 1'b0, 32'd5, 32'd5, 63'd0, 63'd9, 63'd0, 1'b1);  // unsynced
    push_req(REQ_BEGIN, 1'b1, '1, '1, '1, '1, '1, 1'b1);
    push_req(REQ_SNAP_LEVEL, 1'b0, '0, 32'd7, '0, '0, '0, 1'b0);
    push_req(REQ_SNAP_LEVEL, 1'b0, '1, '1, '0, '0, '0, 1'b0);
    push_req(REQ_SNAP_LEVEL, 1'b1, '0, 32'd3, '0, '0, '0, 1'b0);
    push_req(REQ_SNAP_LEVEL, 1'b1, '1, 32'd4, '0, '0, '0, 1'b0);
    push_req(REQ_SNAP_LEVEL, 1'b1, 32'd50, '0, '0, '0, '0, 1'b0);   // zero qty skipped
    push_req(REQ_SNAP_LEVEL, 1'b1, '1, 32'd9, '0, '0, '0, 1'b0);    // update in place
    push_req(REQ_DIFF, 1'b0, 32'd8, 32'd1, 63'd0, 63'd99, 63'd0, 1'b1);  // while loading
    push_req(REQ_COMMIT, 1'b0, '0, '0, '0, 63'd1000, '0, 1'b0);
    push_req(REQ_COMMIT, 1'b0, '0, '0, '0, 63'd1200, '0, 1'b0);     // outside loading
    push_req(REQ_SNAP_LEVEL, 1'b0, 32'd9, 32'd9, '0, '0, '0, 1'b0); // outside loading
    push_req(REQ_DIFF, 1'b0, 32'd8, 32'd1, 63'd990, 63'd1000, 63'd0, 1'b1);  // stale
    push_req(REQ_DIFF, 1'b0, 32'd8, 32'd1, 63'd1001, 63'd1005, 63'd0, 1'b1); // bracket
    push_req(REQ_BEGIN, 1'b0, '0, '0, '0, '0, '0, 1'b0);
    push_req(REQ_SNAP_LEVEL, 1'b0, 32'd40, 32'd2, '0, '0, '0, 1'b0);
    push_req(REQ_COMMIT, 1'b0, '0, '0, '0, 63'd2000, '0, 1'b0);
    push_req(REQ_DIFF, 1'b0, 32'd41, '1, 63'd1995, 63'd2005, 63'd7, 1'b0);
    push_req(REQ_DIFF, 1'b1, 32'd77, '0, 63'd1995, 63'd2005, 63'd7, 1'b0);  // absent
    push_req(REQ_DIFF, 1'b0, 32'd40, '0, 63'd1995, 63'd2005, 63'd7, 1'b1);  // erase
    push_req(REQ_DIFF, 1'b0, 32'd42, 32'd1, 63'd2006, 63'd2008, 63'd2004, 1'b1);  // gap
    push_req(REQ_BEGIN, 1'b0, '0, '0, '0, '0, '0, 1'b0);
    push_req(REQ_COMMIT, 1'b0, '0, '0, '0, top_id - 5, '0, 1'b0);
    push_req(REQ_DIFF, 1'b1, 32'd3, 32'd3, top_id - 9, top_id, '0, 1'b0);
    push_req(REQ_BEGIN, 1'b0, '0, '0, '0, '0, '0, 1'b0);  // closes the open event
    gen_mode = 0;
  endtask

  task automatic gen_random();
    int sel;
    while (items_made < RANDOM_ITEMS + 25) begin
      sel = $urandom_range(0, 99);
      if (gen_mode == 0 || sel < 8) begin
        gen_snapshot($urandom_range(0, 6));
      end else if (sel < 70) begin
        gen_good_event();
      end else if (sel < 76) begin
        // stale: final id at or below the last one
        gen_event($urandom_range(1, 3), rand_id(),
                  gen_last_id - ID_W'($urandom_range(0, 3)), gen_last_id);
      end else if (sel < 80) begin
        gen_event($urandom_range(1, 3), gen_last_id + 1, gen_last_id + 3,
                  gen_last_id + ID_W'($urandom_range(1, 9)));
        if (gen_mode == 2) gen_mode = 0;
        else gen_last_id = gen_last_id + 3;  // awaiting: the event brackets
        if (gen_mode == 1) gen_mode = 2;
      end else if (sel < 83) begin
        gen_event($urandom_range(1, 2), gen_last_id + 2, gen_last_id + 4, rand_id());
        if (gen_mode == 1) gen_mode = 0;
        else gen_mode = 0;  // a gap in sync too, unless prev happened to match
      end else begin
        // noise: fully random beats, may open or break events
        for (int k = $urandom_range(1, 3); k > 0; k--) begin
          push_req(2'($urandom), 1'($urandom), $urandom, $urandom, rand_id(), rand_id(),
                   rand_id(), 1'($urandom));
          gen_mode = 0;
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // driver: bursts of random length separated by random gaps
  // ---------------------------------------------------------------------------
  int burst_left = 4;
  int gap_left = 0;
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      req <= '0;
    end else begin
      if (start && !busy) expected_rsps.insert(expected_rsps.size(), book_step(req));
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          req <= pending_reqs.pop_front();
          start <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 20);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: every done beat against the oldest expectation
  // ---------------------------------------------------------------------------
  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    rsp_t want;
    if (!rst && done) begin
      if (expected_rsps.size() == 0) begin
        $error("result beat with no expectation waiting");
        fail_count++;
      end else begin
        want = expected_rsps.pop_front();
        check_field("status", 64'(want.status), 64'(rsp.status));
        check_field("best_bid_price", 64'(want.best_bid_price), 64'(rsp.best_bid_price));
        check_field("best_ask_price", 64'(want.best_ask_price), 64'(rsp.best_ask_price));
        check_field("bid_level_count", 64'(want.bid_level_count),
                    64'(rsp.bid_level_count));
        check_field("ask_level_count", 64'(want.ask_level_count),
                    64'(rsp.ask_level_count));
        check_field("book_update_id", 64'(want.book_update_id), 64'(rsp.book_update_id));
        check_field("in_sync", 64'(want.in_sync), 64'(rsp.in_sync));
      end
    end
  end

  // watchdog: cycles with neither an accepted request nor a result beat
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("order_book_level_sync: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    gen_directed();
    gen_random();
    repeat (5) @(posedge clk);
    rst <= 1'b1;
    @(posedge clk);
    rst <= 1'b0;
    while (pending_reqs.size() > 0 || start || expected_rsps.size() > 0) @(negedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && expected_rsps.size() == 0) begin
      $display("order_book_level_sync: match");
    end else begin
      $display("order_book_level_sync: mismatch");
    end
    $finish;
  end

endmodule
